@@ design/iil_pkg.sv @@
`timescale 1ns / 1ps
// Package for the indexed integer list engine.
// Holds sizes, command and status codes, and the structs passed along the cell chain.
// No dependencies.
package iil_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int CNT_W    = 7;
    localparam int STAT_W   = 2;
    localparam int CMP_A    = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam int CMP_W    = (CMP_A > CNT_W) ? CMP_A : CNT_W;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Broadcast to every cell for the duration of one walk
    typedef struct packed {
        logic [CMD_W-1:0]         op;
        logic [POS_W-1:0]         pos;
        logic [CNT_W-1:0]         cnt;
        logic signed [DATA_W-1:0] key;
    } chain_ctl_t;

    // Token handed from cell to cell, one cell per cycle
    typedef struct packed {
        logic                     valid;
        logic                     matched;
        logic signed [DATA_W-1:0] carry;
    } chain_tok_t;

endpackage

@@ design/indexed_int_list_engine.sv @@
`timescale 1ns / 1ps
// Top level of the indexed integer list engine: sequencer plus a chain of entry cells.
// Depends on iil_pkg, iil_cell and iil_ctrl.
//
//   channel   handshake          payload
//   request   start / busy       cmd, position, operand_value
//   result    done (one cycle)   result_value, found, status, count_after
//
// A list command walks a token through all CAPACITY cells, one cell per cycle:
// done rises once the token leaves the last cell, and the next accept follows after done.
// Rejected and unused commands skip the walk and go straight to done.
// Reset clears the count and the token chain; entries stay undefined until written.
// The receiver cannot stall: done is high for exactly one cycle per request.
module indexed_int_list_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [iil_pkg::CMD_W-1:0]         cmd,
    input  logic [iil_pkg::POS_W-1:0]         position,
    input  logic signed [iil_pkg::DATA_W-1:0] operand_value,
    output logic                              done,
    output logic signed [iil_pkg::DATA_W-1:0] result_value,
    output logic                              found,
    output logic [iil_pkg::STAT_W-1:0]        status,
    output logic [iil_pkg::CNT_W-1:0]         count_after
);
    import iil_pkg::*;

    chain_ctl_t               ctl;
    chain_tok_t               tok [CAPACITY+1];
    logic signed [DATA_W-1:0] entry [CAPACITY+1];

    iil_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .position      (position),
        .operand_value (operand_value),
        .tail_tok      (tok[CAPACITY]),
        .ctl           (ctl),
        .launch        (tok[0]),
        .busy          (busy),
        .done          (done),
        .result_value  (result_value),
        .found         (found),
        .status        (status),
        .count_after   (count_after)
    );

    assign entry[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        iil_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (IDX_W'(g)),
            .ctl        (ctl),
            .tok_in     (tok[g]),
            .next_entry (entry[g+1]),
            .entry      (entry[g]),
            .tok_out    (tok[g+1])
        );
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy ##1 !busy)
        else $error("done not followed by idle");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> count_after <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != STAT_OK |-> result_value == '0 && !found)
        else $error("error result carries data");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != STAT_OK |-> $stable(count_after))
        else $error("rejected request changed the count");

endmodule

@@ design/iil_cell.sv @@
`timescale 1ns / 1ps
// One list entry of the cell chain with its token stage.
// Depends on iil_pkg.
module iil_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [iil_pkg::IDX_W-1:0]        idx,
    input  iil_pkg::chain_ctl_t              ctl,
    input  iil_pkg::chain_tok_t              tok_in,
    input  logic signed [iil_pkg::DATA_W-1:0] next_entry,
    output logic signed [iil_pkg::DATA_W-1:0] entry,
    output iil_pkg::chain_tok_t              tok_out
);
    import iil_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    chain_tok_t               tok_reg;
    chain_tok_t               tok_next;
    logic [CMP_W-1:0]         i_c;
    logic [CMP_W-1:0]         p_c;
    logic [CMP_W-1:0]         c_c;
    logic                     hit;

    assign i_c = CMP_W'(idx);
    assign p_c = CMP_W'(ctl.pos);
    assign c_c = CMP_W'(ctl.cnt);

    always_comb
    begin
        entry_next = entry_reg;
        tok_next   = tok_in;
        hit        = 1'b0;
        if (tok_in.valid)
        begin
            case (ctl.op)
                CMD_INSERT:
                begin
                    if (i_c >= p_c && i_c <= c_c)
                    begin
                        entry_next     = tok_in.carry;
                        tok_next.carry = entry_reg;
                    end
                end
                CMD_POP:
                begin
                    if (i_c >= p_c && i_c < c_c)
                    begin
                        entry_next = next_entry;
                        if (i_c == p_c)
                        begin
                            tok_next.carry = entry_reg;
                        end
                    end
                end
                CMD_REMOVE:
                begin
                    if (i_c < c_c)
                    begin
                        hit = !tok_in.matched && (entry_reg == ctl.key);
                        if (hit || tok_in.matched)
                        begin
                            entry_next = next_entry;
                        end
                        tok_next.matched = tok_in.matched | hit;
                    end
                end
                CMD_READ:
                begin
                    if (i_c == p_c)
                    begin
                        tok_next.carry = entry_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign entry   = entry_reg;
    assign tok_out = tok_reg;

endmodule

@@ design/iil_ctrl.sv @@
`timescale 1ns / 1ps
// Request sequencer: range checks, token launch, entry count and result register.
// Depends on iil_pkg.
module iil_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [iil_pkg::CMD_W-1:0]         cmd,
    input  logic [iil_pkg::POS_W-1:0]         position,
    input  logic signed [iil_pkg::DATA_W-1:0] operand_value,
    input  iil_pkg::chain_tok_t               tail_tok,
    output iil_pkg::chain_ctl_t               ctl,
    output iil_pkg::chain_tok_t               launch,
    output logic                              busy,
    output logic                              done,
    output logic signed [iil_pkg::DATA_W-1:0] result_value,
    output logic                              found,
    output logic [iil_pkg::STAT_W-1:0]        status,
    output logic [iil_pkg::CNT_W-1:0]         count_after
);
    import iil_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    chain_ctl_t               ctl_reg, ctl_next;
    chain_tok_t               launch_reg, launch_next;
    logic signed [DATA_W-1:0] result_reg, result_next;
    logic                     found_reg, found_next;
    logic [STAT_W-1:0]        status_reg, status_next;
    logic                     accept;
    logic                     full;
    logic [CMP_W-1:0]         pos_c;
    logic [CMP_W-1:0]         cnt_c;

    assign accept = start && (state_reg == ST_IDLE);
    assign full   = (count_reg >= CNT_W'(CAPACITY));
    assign pos_c  = CMP_W'(position);
    assign cnt_c  = CMP_W'(count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ctl_next    = ctl_reg;
        launch_next = '0;
        result_next = result_reg;
        found_next  = found_reg;
        status_next = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next   = '0;
                    found_next    = 1'b0;
                    status_next   = STAT_OK;
                    ctl_next.op   = cmd;
                    ctl_next.pos  = position;
                    ctl_next.cnt  = count_reg;
                    ctl_next.key  = operand_value;
                    launch_next.carry = operand_value;
                    state_next    = ST_WALK;
                    case (cmd)
                        CMD_APPEND:
                        begin
                            ctl_next.op  = CMD_INSERT;
                            ctl_next.pos = POS_W'(count_reg);
                            if (full)
                            begin
                                status_next = STAT_FULL;
                                state_next  = ST_DONE;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (pos_c > cnt_c)
                            begin
                                status_next = STAT_RANGE;
                                state_next  = ST_DONE;
                            end
                            else if (full)
                            begin
                                status_next = STAT_FULL;
                                state_next  = ST_DONE;
                            end
                        end
                        CMD_POP, CMD_READ:
                        begin
                            launch_next.carry = '0;
                            if (pos_c >= cnt_c)
                            begin
                                status_next = STAT_RANGE;
                                state_next  = ST_DONE;
                            end
                        end
                        CMD_REMOVE:
                        begin
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                    launch_next.valid = (state_next == ST_WALK);
                end
            end
            ST_WALK:
            begin
                if (tail_tok.valid)
                begin
                    state_next = ST_DONE;
                    case (ctl_reg.op)
                        CMD_INSERT:
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        CMD_POP:
                        begin
                            count_next  = count_reg - 1'b1;
                            result_next = tail_tok.carry;
                        end
                        CMD_REMOVE:
                        begin
                            found_next = tail_tok.matched;
                            if (tail_tok.matched)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            result_next = tail_tok.carry;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            launch_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            launch_reg <= launch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg    <= ctl_next;
        result_reg <= result_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign ctl          = ctl_reg;
    assign launch       = launch_reg;
    assign busy         = (state_reg != ST_IDLE);
    assign done         = (state_reg == ST_DONE);
    assign result_value = result_reg;
    assign found        = found_reg;
    assign status       = status_reg;
    assign count_after  = count_reg;

endmodule
